>>> src/posture_dwell_rep_counter_macros.svh
// Assertion helpers shared by the posture dwell repetition counter.
`ifndef POSTURE_DWELL_REP_COUNTER_MACROS_SVH
`define POSTURE_DWELL_REP_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PDRC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PDRC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/pdrc_pkg.sv
`default_nettype none

package pdrc_pkg;

   // Angle lanes: yaw, roll, pitch of the first sensor, then of the second
   localparam int NUM_LANES = 6;
   localparam int ANG_W     = 14;
   localparam int ROLL1_LANE = 1;
   localparam int ROLL2_LANE = 4;

   localparam int THR_W  = 13;
   localparam int MS_W   = 16;
   localparam int TIME_W = 32;
   localparam int REP_W  = 4;
   localparam int NUM_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   // signed deviation plus one bit for the negated threshold
   localparam int DEV_W = ANG_W + 2;

   localparam logic [THR_W-1:0] POSE_TOL_RST = THR_W'(96);
   localparam logic [THR_W-1:0] SQ_ENTER_RST = THR_W'(192);
   localparam logic [THR_W-1:0] SQ_EXIT_RST  = THR_W'(96);
   localparam logic [MS_W-1:0]  HOLD_MS_RST  = MS_W'(2000);
   localparam logic [MS_W-1:0]  SQ_MIN_RST   = MS_W'(200);
   localparam logic [REP_W-1:0] REP_MAX      = REP_W'(15);

   // Item codes; a pending code of CMD_TICK means nothing is pending
   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_INIT     = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_RESET    = 3'd3,
      CMD_SAVE     = 3'd4,
      CMD_SET_REPS = 3'd5,
      CMD_OTHER    = 3'd6
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_POSE_TOL = 3'd0,
      REG_SQ_ENTER = 3'd1,
      REG_SQ_EXIT  = 3'd2,
      REG_HOLD_MS  = 3'd3,
      REG_SQ_MIN   = 3'd4
   } reg_index_type;

   typedef logic signed [ANG_W-1:0] angle_type;
   typedef angle_type [NUM_LANES-1:0] angle_vec_type;

   typedef struct packed {
      logic [THR_W-1:0] pose_tol;
      logic [THR_W-1:0] sq_enter;
      logic [THR_W-1:0] sq_exit;
      logic [MS_W-1:0]  hold_ms;
      logic [MS_W-1:0]  sq_min_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]              cmd;
      logic [TIME_W-1:0]       now_ms;
      angle_vec_type           ang;
      logic signed [NUM_W-1:0] rep_number;
   } req_item_type;

   typedef struct packed {
      logic             squatting;
      logic             squat_changed;
      logic             rep_ok;
      logic [REP_W-1:0] reps_done;
      logic [REP_W-1:0] reps_goal;
      logic             set_ok;
      logic             pose_saved;
      logic             set_active;
   } rsp_item_type;

   // What one lane finds about its angle
   typedef struct packed {
      logic within_tol;
      logic above_enter;
      logic below_exit;
   } lane_flag_type;

   typedef lane_flag_type [NUM_LANES-1:0] lane_flag_vec_type;

   // Merged view of all lanes
   typedef struct packed {
      logic pose_ok;
      logic squat_det;
      logic squat_exit;
   } lane_sum_type;

endpackage

`default_nettype wire

>>> src/pdrc_if.sv
`default_nettype none

// Request channel: one tick or command per transfer
interface pdrc_req_if;
   import pdrc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [2:0]              cmd;
   logic [TIME_W-1:0]       now_ms;
   logic signed [ANG_W-1:0] imu1_yaw;
   logic signed [ANG_W-1:0] imu1_roll;
   logic signed [ANG_W-1:0] imu1_pitch;
   logic signed [ANG_W-1:0] imu2_yaw;
   logic signed [ANG_W-1:0] imu2_roll;
   logic signed [ANG_W-1:0] imu2_pitch;
   logic signed [NUM_W-1:0] rep_number;

   modport source (
      output valid, cmd, now_ms, imu1_yaw, imu1_roll, imu1_pitch,
             imu2_yaw, imu2_roll, imu2_pitch, rep_number,
      input  ready
   );
   modport sink (
      input  valid, cmd, now_ms, imu1_yaw, imu1_roll, imu1_pitch,
             imu2_yaw, imu2_roll, imu2_pitch, rep_number,
      output ready
   );
endinterface

// Response channel: one result per request
interface pdrc_rsp_if;
   import pdrc_pkg::*;

   logic             valid;
   logic             ready;
   logic             squatting;
   logic             squat_changed;
   logic             rep_ok;
   logic [REP_W-1:0] reps_done;
   logic [REP_W-1:0] reps_goal;
   logic             set_ok;
   logic             pose_saved;
   logic             set_active;

   modport source (
      output valid, squatting, squat_changed, rep_ok, reps_done, reps_goal,
             set_ok, pose_saved, set_active,
      input  ready
   );
   modport sink (
      input  valid, squatting, squat_changed, rep_ok, reps_done, reps_goal,
             set_ok, pose_saved, set_active,
      output ready
   );
endinterface

`default_nettype wire

>>> src/pdrc_lane.sv
`default_nettype none

module pdrc_lane
   import pdrc_pkg::*;
(
   input  wire angle_type     angle,
   input  wire angle_type     ref_angle,
   input  wire cfg_type       cfg,
   output lane_flag_type      flags
);

   logic signed [DEV_W-1:0] dev;
   logic signed [DEV_W-1:0] tol_s;
   logic signed [DEV_W-1:0] enter_s;
   logic signed [DEV_W-1:0] exit_s;

   // Signed deviation from the reference, compared against +/- thresholds
   always_comb begin
      dev     = DEV_W'(angle) - DEV_W'(ref_angle);
      tol_s   = $signed({{(DEV_W-THR_W){1'b0}}, cfg.pose_tol});
      enter_s = $signed({{(DEV_W-THR_W){1'b0}}, cfg.sq_enter});
      exit_s  = $signed({{(DEV_W-THR_W){1'b0}}, cfg.sq_exit});

      flags.within_tol  = (dev <= tol_s) && (dev >= -tol_s);
      flags.above_enter = (dev > enter_s) || (dev < -enter_s);
      flags.below_exit  = (dev < exit_s) && (dev > -exit_s);
   end

endmodule

`default_nettype wire

>>> src/pdrc_merge.sv
`default_nettype none

module pdrc_merge
   import pdrc_pkg::*;
(
   input  wire lane_flag_vec_type flags,
   output lane_sum_type           sum
);

   logic all_ok;

   // All six angles in tolerance; squat detection uses the two roll lanes
   always_comb begin
      all_ok = 1'b1;
      for (int i = 0; i < NUM_LANES; i++) begin
         all_ok = all_ok & flags[i].within_tol;
      end
      sum.pose_ok    = all_ok;
      sum.squat_det  = flags[ROLL1_LANE].above_enter | flags[ROLL2_LANE].above_enter;
      sum.squat_exit = flags[ROLL1_LANE].below_exit & flags[ROLL2_LANE].below_exit;
   end

endmodule

`default_nettype wire

>>> src/pdrc_core.sv
`default_nettype none
`include "posture_dwell_rep_counter_macros.svh"

module pdrc_core
   import pdrc_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               fire,
   input  wire req_item_type item,
   input  wire lane_sum_type sum,
   input  wire cfg_type      cfg,
   output angle_vec_type     ref_ang,
   output rsp_item_type      res
);

   // Control state
   logic                    pose_cal_ff, pose_cal_in;
   logic                    set_cfg_ff, set_cfg_in;
   logic [REP_W-1:0]        target_ff, target_in;
   logic [REP_W-1:0]        count_ff, count_in;
   logic                    lock_ff, lock_in;
   logic                    hold_valid_ff, hold_valid_in;
   logic                    sq_valid_ff, sq_valid_in;
   logic                    sq_flag_ff, sq_flag_in;
   cmd_type                 pend_ff, pend_in;
   logic signed [NUM_W-1:0] pend_num_ff, pend_num_in;

   // Payload state
   logic [TIME_W-1:0]       hold_start_ff, hold_start_in;
   logic [TIME_W-1:0]       sq_start_ff, sq_start_in;
   angle_vec_type           ref_ff;
   logic                    ref_we;

   logic [TIME_W-1:0]       hold_base;
   logic [TIME_W-1:0]       sq_base;
   logic [TIME_W-1:0]       hold_elapsed;
   logic [TIME_W-1:0]       sq_elapsed;
   logic [REP_W-1:0]        count_inc;
   logic                    num_in_range;

   assign ref_ang = ref_ff;

   // Elapsed times from the stored start, or zero when starting now
   always_comb begin
      hold_base    = hold_valid_ff ? hold_start_ff : item.now_ms;
      sq_base      = sq_valid_ff ? sq_start_ff : item.now_ms;
      hold_elapsed = item.now_ms - hold_base;
      sq_elapsed   = item.now_ms - sq_base;
      count_inc    = (count_ff < REP_MAX) ? count_ff + REP_W'(1) : REP_MAX;
      num_in_range = !pend_num_ff[NUM_W-1] && (pend_num_ff[NUM_W-2:REP_W] == '0)
                     && (pend_num_ff[REP_W-1:0] != '0);
   end

   // Next state for one item
   always_comb begin
      pose_cal_in   = pose_cal_ff;
      set_cfg_in    = set_cfg_ff;
      target_in     = target_ff;
      count_in      = count_ff;
      lock_in       = lock_ff;
      hold_valid_in = hold_valid_ff;
      hold_start_in = hold_start_ff;
      sq_valid_in   = sq_valid_ff;
      sq_start_in   = sq_start_ff;
      sq_flag_in    = sq_flag_ff;
      pend_in       = pend_ff;
      pend_num_in   = pend_num_ff;
      ref_we        = 1'b0;
      res           = '0;

      case (item.cmd)
         CMD_RESET: begin
            pend_in       = CMD_RESET;
            pose_cal_in   = 1'b0;
            set_cfg_in    = 1'b0;
            target_in     = '0;
            count_in      = '0;
            lock_in       = 1'b0;
            hold_valid_in = 1'b0;
         end
         CMD_SET_REPS: begin
            pend_in     = CMD_SET_REPS;
            pend_num_in = item.rep_number;
         end
         CMD_INIT, CMD_STOP, CMD_SAVE, CMD_OTHER: begin
            pend_in = cmd_type'(item.cmd);
         end
         CMD_TICK: begin
            if (pend_ff == CMD_INIT) begin
               pend_in       = CMD_TICK;
               pose_cal_in   = 1'b0;
               set_cfg_in    = 1'b0;
               target_in     = '0;
               count_in      = '0;
               lock_in       = 1'b0;
               hold_valid_in = 1'b0;
            end else if (!pose_cal_ff) begin
               if (pend_ff == CMD_SAVE) begin
                  pend_in       = CMD_TICK;
                  ref_we        = 1'b1;
                  set_cfg_in    = 1'b0;
                  target_in     = '0;
                  count_in      = '0;
                  lock_in       = 1'b0;
                  hold_valid_in = 1'b0;
                  pose_cal_in   = 1'b1;
                  res.pose_saved = 1'b1;
               end
            end else if (!set_cfg_ff) begin
               if (pend_ff == CMD_SET_REPS) begin
                  pend_in     = CMD_TICK;
                  pend_num_in = '1;
                  if (num_in_range) begin
                     target_in  = pend_num_ff[REP_W-1:0];
                     count_in   = '0;
                     set_cfg_in = 1'b1;
                  end
               end
            end else begin
               // squat detector with hysteresis and entry dwell
               if (sum.squat_det && !sq_flag_ff) begin
                  sq_start_in = sq_base;
                  sq_valid_in = 1'b1;
                  if (sq_elapsed > TIME_W'(cfg.sq_min_ms)) begin
                     sq_flag_in        = 1'b1;
                     res.squat_changed = 1'b1;
                  end
               end else if (!sum.squat_det && sq_flag_ff) begin
                  if (sum.squat_exit) begin
                     sq_flag_in        = 1'b0;
                     sq_valid_in       = 1'b0;
                     res.squat_changed = 1'b1;
                  end
               end else begin
                  sq_valid_in = 1'b0;
               end

               // quit, or the repetition hold
               if (pend_ff == CMD_STOP) begin
                  pend_in       = CMD_TICK;
                  set_cfg_in    = 1'b0;
                  count_in      = '0;
                  lock_in       = 1'b0;
                  hold_valid_in = 1'b0;
               end else if (sum.pose_ok && !lock_ff) begin
                  hold_start_in = hold_base;
                  hold_valid_in = 1'b1;
                  if (hold_elapsed >= TIME_W'(cfg.hold_ms)) begin
                     count_in      = count_inc;
                     lock_in       = 1'b1;
                     res.rep_ok    = 1'b1;
                     res.reps_done = count_inc;
                     hold_valid_in = 1'b0;
                     if (count_inc >= target_ff) begin
                        res.set_ok = 1'b1;
                        set_cfg_in = 1'b0;
                        count_in   = '0;
                        lock_in    = 1'b0;
                     end
                  end
               end else begin
                  hold_valid_in = 1'b0;
                  lock_in       = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      res.squatting  = sq_flag_in;
      res.reps_goal  = target_in;
      res.set_active = set_cfg_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pose_cal_ff   <= 1'b0;
         set_cfg_ff    <= 1'b0;
         target_ff     <= '0;
         count_ff      <= '0;
         lock_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         sq_valid_ff   <= 1'b0;
         sq_flag_ff    <= 1'b0;
         pend_ff       <= CMD_TICK;
         pend_num_ff   <= '1;
      end else if (fire) begin
         pose_cal_ff   <= pose_cal_in;
         set_cfg_ff    <= set_cfg_in;
         target_ff     <= target_in;
         count_ff      <= count_in;
         lock_ff       <= lock_in;
         hold_valid_ff <= hold_valid_in;
         sq_valid_ff   <= sq_valid_in;
         sq_flag_ff    <= sq_flag_in;
         pend_ff       <= pend_in;
         pend_num_ff   <= pend_num_in;
      end
   end

   // Start times and reference pose
   always_ff @(posedge clock) begin
      if (fire) begin
         hold_start_ff <= hold_start_in;
         sq_start_ff   <= sq_start_in;
         if (ref_we) begin
            ref_ff <= item.ang;
         end
      end
   end

   `PDRC_ASSERT_IMP(a_set_needs_pose, clock, reset, set_cfg_ff, pose_cal_ff, "set active without saved pose")
   `PDRC_ASSERT_IMP(a_count_below_goal, clock, reset, set_cfg_ff, count_ff < target_ff, "count reached goal inside set")
   `PDRC_ASSERT_IMP(a_lock_in_set, clock, reset, lock_ff, set_cfg_ff, "lock held outside a set")
   `PDRC_ASSERT_IMP(a_set_done_counts, clock, reset, fire && res.set_ok, res.rep_ok && !res.set_active, "set finished without a counted rep")
   `PDRC_ASSERT_NXT(a_reset_cmd_clears, clock, reset, fire && item.cmd == CMD_RESET, !pose_cal_ff && !set_cfg_ff && pend_ff == CMD_RESET, "reset command did not clear")

endmodule

`default_nettype wire

>>> src/posture_dwell_rep_counter.sv
// Posture dwell repetition counter.
// req_bus carries one item per transfer: a sensor tick (timestamp and six
// signed 1/16-degree angles) or a command. rsp_bus returns exactly one
// result per item, in order. Both use valid/ready; a transfer happens when
// both are high at a rising clock edge.
// The csr_ port writes the five threshold and timing registers by index;
// write only while no item is in flight.
// A transferred request is captured in the input register, which feeds six
// angle lanes, the merge and the state update into the output register that
// drives rsp_bus. Throughput: one item per cycle while rsp_bus.ready is
// high; the state update loops back through the core state registers.
// Reset (synchronous, active high) restores register defaults, clears the
// calibration, set, squat and pending command state, and empties both stages.
// When the receiver stalls, the result holds in the output register while
// one more item waits in the input register; then req_bus.ready drops.
`default_nettype none

module posture_dwell_rep_counter
   import pdrc_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   pdrc_req_if.sink             req_bus,
   pdrc_rsp_if.source           rsp_bus,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DAT_W-1:0]  csr_wdata
);

   cfg_type           cfg_ff;
   logic              stg_valid_ff;
   req_item_type      stg_item_ff;
   logic              rsp_valid_ff;
   rsp_item_type      rsp_item_ff;
   logic              advance;
   angle_vec_type     ref_ang;
   lane_flag_vec_type flags;
   lane_sum_type      sum;
   rsp_item_type      res;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pose_tol  <= POSE_TOL_RST;
         cfg_ff.sq_enter  <= SQ_ENTER_RST;
         cfg_ff.sq_exit   <= SQ_EXIT_RST;
         cfg_ff.hold_ms   <= HOLD_MS_RST;
         cfg_ff.sq_min_ms <= SQ_MIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_POSE_TOL: cfg_ff.pose_tol  <= csr_wdata[THR_W-1:0];
            REG_SQ_ENTER: cfg_ff.sq_enter  <= csr_wdata[THR_W-1:0];
            REG_SQ_EXIT:  cfg_ff.sq_exit   <= csr_wdata[THR_W-1:0];
            REG_HOLD_MS:  cfg_ff.hold_ms   <= csr_wdata[MS_W-1:0];
            REG_SQ_MIN:   cfg_ff.sq_min_ms <= csr_wdata[MS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Stage handshake: an item advances when the output register is empty or being taken
   assign advance       = stg_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !stg_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            stg_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         stg_item_ff.cmd        <= req_bus.cmd;
         stg_item_ff.now_ms     <= req_bus.now_ms;
         stg_item_ff.ang[0]     <= req_bus.imu1_yaw;
         stg_item_ff.ang[1]     <= req_bus.imu1_roll;
         stg_item_ff.ang[2]     <= req_bus.imu1_pitch;
         stg_item_ff.ang[3]     <= req_bus.imu2_yaw;
         stg_item_ff.ang[4]     <= req_bus.imu2_roll;
         stg_item_ff.ang[5]     <= req_bus.imu2_pitch;
         stg_item_ff.rep_number <= req_bus.rep_number;
      end
   end

   // Angle lanes
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      pdrc_lane u_lane (
         .angle     (stg_item_ff.ang[g]),
         .ref_angle (ref_ang[g]),
         .cfg       (cfg_ff),
         .flags     (flags[g])
      );
   end

   pdrc_merge u_merge (
      .flags (flags),
      .sum   (sum)
   );

   pdrc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .item    (stg_item_ff),
      .sum     (sum),
      .cfg     (cfg_ff),
      .ref_ang (ref_ang),
      .res     (res)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= res;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.squatting     = rsp_item_ff.squatting;
   assign rsp_bus.squat_changed = rsp_item_ff.squat_changed;
   assign rsp_bus.rep_ok        = rsp_item_ff.rep_ok;
   assign rsp_bus.reps_done     = rsp_item_ff.reps_done;
   assign rsp_bus.reps_goal     = rsp_item_ff.reps_goal;
   assign rsp_bus.set_ok        = rsp_item_ff.set_ok;
   assign rsp_bus.pose_saved    = rsp_item_ff.pose_saved;
   assign rsp_bus.set_active    = rsp_item_ff.set_active;

endmodule

`default_nettype wire
